// ===== src/cfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, codes and the bytewise CRC-16/MODBUS step for the deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB  = 16'h0001;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hEB;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h90;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4088;

  // Result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
  localparam logic [1:0] KIND_OVERSIZE = 2'd3;

  typedef enum logic [8:0] {
    PH_SYNC1 = 9'b000000001,
    PH_SYNC2 = 9'b000000010,
    PH_VER   = 9'b000000100,
    PH_CMD   = 9'b000001000,
    PH_LENHI = 9'b000010000,
    PH_LENLO = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CRCHI = 9'b010000000,
    PH_CRCLO = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [7:0]  version_byte;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic [15:0] computed_crc;
  } res_t;

  // One byte through the reflected CRC, eight shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_LSB) != 16'h0000) c = (c >> 1) ^ CRC_POLY;
      else                           c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== src/cfd_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_apb_regs
// APB register file: sync word bytes and the payload length limit.
// ----------------------------------------------------------------------------
module cfd_apb_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfd_pkg::cfg_t     cfg
);
  import cfd_pkg::*;

  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic [15:0] max_payload_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        REG_MAX_PAYLOAD: max_payload_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYNC_FIRST:  prdata = {24'h0, sync_first_r};
      REG_SYNC_SECOND: prdata = {24'h0, sync_second_r};
      REG_MAX_PAYLOAD: prdata = {16'h0, max_payload_r};
      default:         prdata = 32'h0;
    endcase
  end

  assign cfg.sync_first  = sync_first_r;
  assign cfg.sync_second = sync_second_r;
  assign cfg.max_payload = max_payload_r;

endmodule

// ===== src/cfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_core
// Frame phase machine and CRC accumulator; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module cfd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [7:0]     rx_byte,
  input  cfd_pkg::cfg_t  cfg,
  output cfd_pkg::res_t  res
);
  import cfd_pkg::*;

  phase_t      phase_r,  phase_nxt;
  logic [15:0] crc_r,    crc_nxt;
  logic [15:0] cnt_r,    cnt_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [7:0]  cmd_r,    cmd_nxt;
  logic [7:0]  ver_r,    ver_nxt;
  logic [7:0]  crchi_r,  crchi_nxt;
  logic [15:0] crc_upd;
  logic [15:0] crc_restart;
  logic [15:0] rx_crc;

  assign crc_upd     = crc16_byte(crc_r, rx_byte);
  assign crc_restart = crc16_byte(CRC_INIT, rx_byte);
  assign rx_crc      = {crchi_r, rx_byte};

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    ver_nxt   = ver_r;
    crchi_nxt = crchi_r;
    res.vld          = 1'b0;
    res.kind         = KIND_DATA;
    res.data_byte    = 8'h00;
    res.computed_crc = 16'h0000;
    unique case (phase_r)
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          crc_nxt   = crc_upd;
          phase_nxt = PH_VER;
        end else if (rx_byte == cfg.sync_first) begin
          crc_nxt   = crc_restart;
          phase_nxt = PH_SYNC2;
        end else begin
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_SYNC1;
        end
      end
      PH_VER: begin
        ver_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt   = {rx_byte, 8'h00};
        crc_nxt   = crc_upd;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt = {len_r[15:8], rx_byte};
        cnt_nxt = 16'h0000;
        if (len_nxt > cfg.max_payload) begin
          res.vld   = 1'b1;
          res.kind  = KIND_OVERSIZE;
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_SYNC1;
        end else begin
          crc_nxt   = crc_upd;
          phase_nxt = (len_nxt == 16'h0000) ? PH_CRCHI : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_r + 16'd1;
        if (cnt_nxt >= len_r) phase_nxt = PH_CRCHI;
        res.vld       = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = rx_byte;
      end
      PH_CRCHI: begin
        crchi_nxt = rx_byte;
        phase_nxt = PH_CRCLO;
      end
      PH_CRCLO: begin
        res.vld          = 1'b1;
        res.kind         = (rx_crc == crc_r) ? KIND_GOOD : KIND_BAD_CRC;
        res.computed_crc = crc_r;
        crc_nxt          = CRC_INIT;
        phase_nxt        = PH_SYNC1;
      end
      default: begin
        // hunting for the first sync byte
        if (rx_byte == cfg.sync_first) begin
          crc_nxt   = crc_restart;
          phase_nxt = PH_SYNC2;
        end else begin
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_SYNC1;
        end
      end
    endcase
    res.command      = cmd_r;
    res.version_byte = ver_r;
    res.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      crc_r   <= CRC_INIT;
      cnt_r   <= 16'h0000;
      len_r   <= 16'h0000;
      cmd_r   <= 8'h00;
      ver_r   <= 8'h00;
      crchi_r <= 8'h00;
    end else if (en) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      ver_r   <= ver_nxt;
      crchi_r <= crchi_nxt;
    end
  end

  // Outside a frame the accumulator holds the initial value.
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SYNC1 |-> crc_r == CRC_INIT)
    else $error("crc not reset while hunting");

  // The payload counter never runs past the declared length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> cnt_r < len_r)
    else $error("payload counter overran length");

  // An oversize drop always sends the machine back to hunting.
  a_drop_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.vld && res.kind == KIND_OVERSIZE |=> phase_r == PH_SYNC1)
    else $error("drop did not resync");

endmodule

// ===== src/crc_checked_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer
// Sync-word / length / CRC-16 MODBUS frame deframer, one byte per item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in_       in         in_valid/in_ready   in_rx_byte
//  out_      out        out_valid/out_ready kind, command, version_byte,
//                                           data_byte, frame_length, computed_crc
//  cfg (APB) in         psel/penable/pready sync_first, sync_second, max_payload
//
//  One item per cycle sustained while the result side is not stalled.
//  The byte-wide CRC step plus phase update sits between the
//  input register and the result register.
//  Synchronous active-low reset returns to hunting for the first sync byte.
//  A stalled result holds the result register; the input register still
//  takes one item, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_command,
  output logic [7:0]  out_version_byte,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_computed_crc,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfd_pkg::*;

  cfg_t        cfg;
  res_t        res;
  res_t        out_r;
  logic        out_vld_r, out_vld_nxt;
  logic        stg_vld_r, stg_vld_nxt;
  logic [7:0]  stg_byte_r;
  logic        stg_adv;
  logic        in_acc;

  cfd_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Staged byte moves through the core only when the result slot is free
  // (or being emptied this cycle), so a result is never overwritten.
  assign stg_adv  = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || stg_adv;
  assign in_acc   = in_valid && in_ready;

  cfd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (stg_adv),
    .rx_byte (stg_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    stg_vld_nxt = in_acc ? 1'b1 : (stg_adv ? 1'b0 : stg_vld_r);
    if (stg_adv)        out_vld_nxt = res.vld;
    else if (out_ready) out_vld_nxt = 1'b0;
    else                out_vld_nxt = out_vld_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) stg_byte_r <= in_rx_byte;
    if (stg_adv && res.vld) out_r <= res;
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_command      = out_r.command;
  assign out_version_byte = out_r.version_byte;
  assign out_data_byte    = out_r.data_byte;
  assign out_frame_length = out_r.frame_length;
  assign out_computed_crc = out_r.computed_crc;

  // Core never advances into a full, stalled result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |-> !stg_adv)
    else $error("result overwritten");

  // An empty input register always takes an item.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_vld_r |-> in_ready)
    else $error("ready low with empty stage");

  // Only payload items carry a data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.kind != KIND_DATA |-> out_r.data_byte == 8'h00)
    else $error("data byte on end item");

  // A staged byte not advanced stays staged.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !stg_adv |=> stg_vld_r && $stable(stg_byte_r))
    else $error("staged byte lost");

endmodule

// ===== tb/sv/crc_checked_frame_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer_test
// Self-checking bench for the sync / length / CRC-16 MODBUS frame deframer.
// A short scripted byte sequence covers the sync edge cases, payload, good and
// bad CRC, oversize and zero-length frames. It is followed by random frames
// under several register settings. Every accepted byte is run through a local
// deframer model, and the results are compared in order, field by field.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_test;

  import cfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PER_PHASE   = 275;     // random bytes per register setting
  localparam int NPHASES     = 6;
  localparam int SETTLE      = 6;
  localparam int NDIR        = 27;

  // One result item as the block presents it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [7:0]  version_byte;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic [15:0] computed_crc;
  } deframe_result_t;

  // How a scripted row picks its byte: as written, or from the running CRC
  typedef enum logic [1:0] {BYTE_RAW, CRC_HI_OK, CRC_LO_OK, CRC_LO_BAD} row_mode_t;

  typedef struct packed {
    row_mode_t       mode;
    logic [7:0]      rx_byte;
    logic            typed;     // expected result written in the row itself
    deframe_result_t want;
  } script_row_t;

  // Scripted part, default registers (sync EB 90, max payload 4088).
  // Rows without a typed result take the expectation from the model below.
  localparam script_row_t SCRIPT [NDIR] = '{
    '{BYTE_RAW,   8'hEB, 1'b0, '0},   // first sync byte
    '{BYTE_RAW,   8'h5C, 1'b0, '0},   // wrong second byte: back to hunting
    '{BYTE_RAW,   8'hEB, 1'b0, '0},
    '{BYTE_RAW,   8'hEB, 1'b0, '0},   // repeated first byte restarts the sync
    '{BYTE_RAW,   8'h90, 1'b0, '0},
    '{BYTE_RAW,   8'hFF, 1'b0, '0},   // version
    '{BYTE_RAW,   8'h00, 1'b0, '0},   // command
    '{BYTE_RAW,   8'h00, 1'b0, '0},   // length 2
    '{BYTE_RAW,   8'h02, 1'b0, '0},
    '{BYTE_RAW,   8'hFF, 1'b1, '{KIND_DATA, 8'h00, 8'hFF, 8'hFF, 16'h0002, 16'h0000}},
    '{BYTE_RAW,   8'h00, 1'b1, '{KIND_DATA, 8'h00, 8'hFF, 8'h00, 16'h0002, 16'h0000}},
    '{CRC_HI_OK,  8'h00, 1'b0, '0},
    '{CRC_LO_OK,  8'h00, 1'b0, '0},   // frame good
    '{BYTE_RAW,   8'hEB, 1'b0, '0},
    '{BYTE_RAW,   8'h90, 1'b0, '0},
    '{BYTE_RAW,   8'h00, 1'b0, '0},
    '{BYTE_RAW,   8'hFF, 1'b0, '0},
    '{BYTE_RAW,   8'hFF, 1'b0, '0},   // length FFFF: dropped
    '{BYTE_RAW,   8'hFF, 1'b1, '{KIND_OVERSIZE, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 16'h0000}},
    '{BYTE_RAW,   8'hEB, 1'b0, '0},
    '{BYTE_RAW,   8'h90, 1'b0, '0},
    '{BYTE_RAW,   8'h7E, 1'b0, '0},
    '{BYTE_RAW,   8'h81, 1'b0, '0},
    '{BYTE_RAW,   8'h00, 1'b0, '0},   // zero length: straight to the CRC
    '{BYTE_RAW,   8'h00, 1'b0, '0},
    '{CRC_HI_OK,  8'h00, 1'b0, '0},
    '{CRC_LO_BAD, 8'h00, 1'b0, '0}    // crc mismatch
  };

  // --------------------------------------------------------------------------
  // DUT signals, inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_command;
  logic [7:0]  out_version_byte;
  logic [7:0]  out_data_byte;
  logic [15:0] out_frame_length;
  logic [15:0] out_computed_crc;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = 4'h0;
  logic [31:0] pwdata     = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  crc_checked_frame_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_command      (out_command),
    .out_version_byte (out_version_byte),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .out_computed_crc (out_computed_crc),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deframer model: register copies and frame state
  // --------------------------------------------------------------------------
  logic [7:0]  want_sync_first  = SYNC_FIRST_RST;
  logic [7:0]  want_sync_second = SYNC_SECOND_RST;
  logic [15:0] want_max_payload = MAX_PAYLOAD_RST;

  phase_t      hunt_phase  = PH_SYNC1;
  logic [15:0] running_crc = CRC_INIT;
  logic [15:0] payload_seen = 16'h0;
  logic [15:0] hdr_length  = 16'h0;
  logic [7:0]  hdr_command = 8'h0;
  logic [7:0]  hdr_version = 8'h0;
  logic [7:0]  rx_crc_hi   = 8'h0;

  deframe_result_t pending_results [$];

  int  errors     = 0;
  int  bytes_fed  = 0;
  int  cycles     = 0;
  int  tally [4]  = '{0, 0, 0, 0};
  bit  calm       = 1'b0;   // no idling on either side while set

  // Reflected CRC-16/MODBUS, one byte, bit-serial
  function automatic logic [15:0] modbus_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Advance the frame state by one byte; returns 1 when a result is due
  function automatic bit deframe_byte(input logic [7:0] b, output deframe_result_t r);
    bit emits;
    emits = 1'b0;
    r = '0;
    case (hunt_phase)
      PH_SYNC2: begin
        if (b == want_sync_second) begin
          running_crc = modbus_step(running_crc, b);
          hunt_phase = PH_VER;
        end else if (b == want_sync_first) begin
          running_crc = modbus_step(CRC_INIT, b);
          hunt_phase = PH_SYNC2;
        end else begin
          running_crc = CRC_INIT;
          hunt_phase = PH_SYNC1;
        end
      end
      PH_VER: begin
        hdr_version = b;
        running_crc = modbus_step(running_crc, b);
        hunt_phase = PH_CMD;
      end
      PH_CMD: begin
        hdr_command = b;
        running_crc = modbus_step(running_crc, b);
        hunt_phase = PH_LENHI;
      end
      PH_LENHI: begin
        hdr_length = {b, 8'h00};
        running_crc = modbus_step(running_crc, b);
        hunt_phase = PH_LENLO;
      end
      PH_LENLO: begin
        hdr_length = {hdr_length[15:8], b};
        running_crc = modbus_step(running_crc, b);
        payload_seen = 16'h0;
        if (hdr_length > want_max_payload) begin
          r = '{KIND_OVERSIZE, hdr_command, hdr_version, 8'h00, hdr_length, 16'h0000};
          emits = 1'b1;
          running_crc = CRC_INIT;
          hunt_phase = PH_SYNC1;
        end else begin
          hunt_phase = (hdr_length == 16'h0) ? PH_CRCHI : PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc = modbus_step(running_crc, b);
        payload_seen = payload_seen + 16'h1;
        if (payload_seen >= hdr_length) hunt_phase = PH_CRCHI;
        r = '{KIND_DATA, hdr_command, hdr_version, b, hdr_length, 16'h0000};
        emits = 1'b1;
      end
      PH_CRCHI: begin
        rx_crc_hi = b;
        hunt_phase = PH_CRCLO;
      end
      PH_CRCLO: begin
        r = '{({rx_crc_hi, b} == running_crc) ? KIND_GOOD : KIND_BAD_CRC,
              hdr_command, hdr_version, 8'h00, hdr_length, running_crc};
        emits = 1'b1;
        running_crc = CRC_INIT;
        hunt_phase = PH_SYNC1;
      end
      default: begin
        if (b == want_sync_first) begin
          running_crc = modbus_step(CRC_INIT, b);
          hunt_phase = PH_SYNC2;
        end else begin
          running_crc = CRC_INIT;
          hunt_phase = PH_SYNC1;
        end
      end
    endcase
    return emits;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 15);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one byte per handshake, random gaps before it
  // --------------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input deframe_result_t want = '0);
    deframe_result_t r;
    bit emits;
    @(negedge clk);
    while (take_break()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    emits = deframe_byte(b, r);
    // scripted rows carry their own result; the model still tracks the frame
    if (typed) pending_results = {pending_results, want};
    else if (emits) pending_results = {pending_results, r};
    bytes_fed++;
  endtask

  // Stop sending and wait for every outstanding result, plus the pipeline
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write, then read back the same register
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_MAX_PAYLOAD) ? 32'h0000_FFFF : 32'h0000_00FF;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SYNC_FIRST:  want_sync_first  = value[7:0];
      REG_SYNC_SECOND: want_sync_second = value[7:0];
      REG_MAX_PAYLOAD: want_max_payload = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t ns: register %0d readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, idx, value & mask, prdata & mask);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // One random sequence: mostly well-formed frames with random content,
  // some line noise, lone sync bytes, truncated frames and corrupted CRCs
  task automatic send_random_frame();
    int          pick, lr, n;
    logic [15:0] len, crc;
    logic [7:0]  hdr [6];
    logic [7:0]  b;
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 8) begin
      feed_byte(want_sync_first);
      feed_byte(8'($urandom_range(255)));
      return;
    end
    lr = $urandom_range(99);
    if (lr < 10 && want_max_payload != 16'hFFFF)
      len = ($urandom_range(1) != 0) ? want_max_payload + 16'h1
                                     : 16'($urandom_range(65535, want_max_payload + 1));
    else if (lr < 20)
      len = 16'h0;
    else if (lr < 30 && want_max_payload <= 16'd40)
      len = want_max_payload;
    else
      len = 16'($urandom_range(0, (want_max_payload < 16'd16) ? want_max_payload : 16));
    hdr = '{want_sync_first, want_sync_second, 8'($urandom_range(255)),
            8'($urandom_range(255)), len[15:8], len[7:0]};
    crc = CRC_INIT;
    foreach (hdr[i]) begin
      crc = modbus_step(crc, hdr[i]);
      feed_byte(hdr[i]);
    end
    if (len > want_max_payload) return;
    // truncated frame: the next bytes land in the payload or CRC
    n = (pick < 13) ? int'($urandom_range(0, len)) : int'(len);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      crc = modbus_step(crc, b);
      feed_byte(b);
    end
    if (pick < 13) return;
    if ($urandom_range(99) < 25) crc = crc ^ 16'($urandom_range(1, 65535));
    feed_byte(crc[15:8]);
    feed_byte(crc[7:0]);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, in-order compare
  // --------------------------------------------------------------------------
  always @(negedge clk) out_ready = !take_break();

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual kind %0d data 0x%0h",
                 $time, out_kind, out_data_byte);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind",         16'(want.kind),         16'(out_kind));
        check_field("command",      16'(want.command),      16'(out_command));
        check_field("version_byte", 16'(want.version_byte), 16'(out_version_byte));
        check_field("data_byte",    16'(want.data_byte),    16'(out_data_byte));
        check_field("frame_length", want.frame_length,      out_frame_length);
        check_field("computed_crc", want.computed_crc,      out_computed_crc);
      end
      if (!$isunknown(out_kind)) tally[out_kind]++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  b;
    logic [31:0] settings [NPHASES][3];
    int          phase_start;
    bit          paused;

    // sync first, sync second, max payload; extremes plus equal sync bytes
    settings = '{'{32'hEB, 32'h90, 32'd4088},
                 '{32'h00, 32'hFF, 32'd0},
                 '{32'hFF, 32'h00, 32'd65535},
                 '{32'h55, 32'h55, 32'd8},
                 '{32'hA5, 32'h5A, 32'd3},
                 '{32'($urandom_range(255)), 32'($urandom_range(255)),
                   32'($urandom_range(1, 40))}};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // scripted part on the reset register values
    for (int i = 0; i < NDIR; i++) begin
      case (SCRIPT[i].mode)
        CRC_HI_OK:  b = running_crc[15:8];
        CRC_LO_OK:  b = running_crc[7:0];
        CRC_LO_BAD: b = ~running_crc[7:0];
        default:    b = SCRIPT[i].rx_byte;
      endcase
      feed_byte(b, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // random part; registers change only with the block idle.
    // The second setting runs with no idling at all.
    for (int p = 0; p < NPHASES; p++) begin
      drain();
      if (p > 0) begin
        program_reg(REG_SYNC_FIRST,  settings[p][0]);
        program_reg(REG_SYNC_SECOND, settings[p][1]);
        program_reg(REG_MAX_PAYLOAD, settings[p][2]);
      end
      calm = (p == 1);
      phase_start = bytes_fed;
      paused = 1'b0;
      while (bytes_fed - phase_start < PER_PHASE) begin
        send_random_frame();
        // sender holds off mid-setting until all results are back
        if (!paused && bytes_fed - phase_start >= PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    calm = 1'b0;
    drain();

    $display("Fed %0d bytes under %0d register settings.", bytes_fed, NPHASES);
    $display("Results: %0d payload, %0d good frames, %0d crc errors, %0d oversize drops.",
             tally[KIND_DATA], tally[KIND_GOOD], tally[KIND_BAD_CRC], tally[KIND_OVERSIZE]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== crc_checked_frame_deframer.f =====
src/cfd_pkg.sv
src/cfd_apb_regs.sv
src/cfd_core.sv
src/crc_checked_frame_deframer.sv
tb/sv/crc_checked_frame_deframer_test.sv
